// File: hdl/cbpt_pkg.sv
// Shared types, constants and fixed-point helpers for the cubic Bezier
// point/tangent evaluator. No dependencies; imported by every other file.
`default_nettype none

package cbpt_pkg;

   // Datapath sizing
   localparam int COORD_WIDTH = 16;
   localparam int FRAC_WIDTH  = 16;

   // Fixed field widths of the ports
   localparam int T_W        = 16;
   localparam int INV_W      = 32;
   localparam int REG_W      = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int POS_W      = 16;
   localparam int TAN_W      = 19;
   localparam int NUM_AXES   = 3;
   localparam int NUM_POINTS = 4;

   // Derived widths
   localparam int NORM_W    = T_W + INV_W;
   localparam int Q_W       = 17;
   localparam int Q_EXT_W   = Q_W + 8;
   localparam int TN_W      = FRAC_WIDTH + 1;
   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int PROD_W    = COORD_WIDTH + FRAC_WIDTH + 3;
   localparam int TAN_RAW_W = COORD_WIDTH + 3;
   localparam int SAT_W     = (TAN_RAW_W > TAN_W + 1) ? TAN_RAW_W : TAN_W + 1;
   localparam int PAD_W     = (NUM_AXES * COORD_WIDTH > REG_W) ?
                              NUM_AXES * COORD_WIDTH : REG_W;

   // Q16 to FRAC_WIDTH conversion: shift left, or shift right with rounding
   localparam int TN_SHL = (FRAC_WIDTH > 16) ? FRAC_WIDTH - 16 : 0;
   localparam int TN_SHR = (FRAC_WIDTH < 16) ? 16 - FRAC_WIDTH : 0;
   localparam int TN_RND = (TN_SHR > 0) ? 2 ** (TN_SHR - 1) : 0;

   typedef logic [T_W-1:0]              t_type;
   typedef logic [INV_W-1:0]            inv_span_type;
   typedef logic [REG_W-1:0]            point_type;
   typedef logic [CSR_IDX_W-1:0]        csr_idx_type;
   typedef logic [NORM_W-1:0]           norm_type;
   typedef logic [Q_W-1:0]              q_type;
   typedef logic [Q_EXT_W-1:0]          q_ext_type;
   typedef logic [TN_W-1:0]             tn_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]    diff_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic signed [TAN_RAW_W-1:0] tan_raw_type;
   typedef logic signed [SAT_W-1:0]     sat_type;
   typedef logic signed [POS_W-1:0]     pos_type;
   typedef logic signed [TAN_W-1:0]     tan_type;

   // Register indexes
   localparam csr_idx_type CSR_POINT0     = 3'd0;
   localparam csr_idx_type CSR_POINT1     = 3'd1;
   localparam csr_idx_type CSR_POINT2     = 3'd2;
   localparam csr_idx_type CSR_POINT3     = 3'd3;
   localparam csr_idx_type CSR_T_MIN      = 3'd4;
   localparam csr_idx_type CSR_T_INV_SPAN = 3'd5;

   localparam inv_span_type INV_SPAN_RESET = inv_span_type'(65536);
   localparam q_type        Q_ONE          = q_type'(65536);
   localparam norm_type     NORM_ONE       = norm_type'(65536);
   localparam tn_type       TN_ONE         = tn_type'(2 ** FRAC_WIDTH);
   localparam q_ext_type    Q_RND          = q_ext_type'(TN_RND);
   localparam prod_type     LERP_HALF      = prod_type'(2 ** (FRAC_WIDTH - 1));

   // Output saturation bounds
   localparam sat_type POS_HI = sat_type'(2 ** (POS_W - 1) - 1);
   localparam sat_type POS_LO = sat_type'(-(2 ** (POS_W - 1)));
   localparam sat_type TAN_HI = sat_type'(2 ** (TAN_W - 1) - 1);
   localparam sat_type TAN_LO = sat_type'(-(2 ** (TAN_W - 1)));

   // Normalized parameter handed from the front end to the lerp pipeline
   typedef struct packed {
      logic   valid;
      logic   err;
      tn_type tn;
   } tnorm_type;

   // One signed coordinate out of a packed control point
   function automatic coord_type coord_sel(input point_type p, input int axis);
      logic [PAD_W-1:0] w;
      w = PAD_W'(p);
      return coord_type'(w[axis*COORD_WIDTH +: COORD_WIDTH]);
   endfunction

   // First half of a lerp: (b - a) * tN
   function automatic prod_type lerp_mul(input coord_type a, input coord_type b,
                                         input tn_type tn);
      diff_type d;
      d = diff_type'(b) - diff_type'(a);
      return prod_type'(d) * prod_type'({1'b0, tn});
   endfunction

   // Second half: a + floor((prod + half) / 2^FRAC_WIDTH); result stays in range
   function automatic coord_type lerp_end(input coord_type a, input prod_type p);
      prod_type r;
      r = (p + LERP_HALF) >>> FRAC_WIDTH;
      return coord_type'(a + coord_type'(r[COORD_WIDTH-1:0]));
   endfunction

   function automatic sat_type sat_clip(input sat_type v, input sat_type hi,
                                        input sat_type lo);
      sat_type r;
      r = v;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hdl/cbpt_if.sv
// Valid/ready channel interfaces: parameter requests, results and
// register writes. Depends on cbpt_pkg.
`default_nettype none

interface cbpt_req_if import cbpt_pkg::*; ();
   logic  valid;
   logic  ready;
   t_type t_value;

   modport source (output valid, output t_value, input ready);
   modport sink   (input valid, input t_value, output ready);
endinterface

interface cbpt_rsp_if import cbpt_pkg::*; ();
   logic    valid;
   logic    ready;
   pos_type pos_x;
   pos_type pos_y;
   pos_type pos_z;
   tan_type tan_x;
   tan_type tan_y;
   tan_type tan_z;
   logic    range_error;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output tan_x, output tan_y, output tan_z,
                   output range_error, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input tan_x, input tan_y, input tan_z,
                   input range_error, output ready);
endinterface

interface cbpt_csr_if import cbpt_pkg::*; ();
   logic        valid;
   logic        ready;
   csr_idx_type index;
   point_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/cbpt_tnorm.sv
// Two-stage parameter normalizer: (t - t_min) * inverse span, clamp to
// [0,1], convert to FRAC_WIDTH fraction bits. Depends on cbpt_pkg.
`default_nettype none

module cbpt_tnorm import cbpt_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire logic         in_valid,
   input  wire t_type        t_value,
   input  wire t_type        t_min,
   input  wire inv_span_type t_inv_span,
   output tnorm_type         norm_out
);

   // Stage A: offset and scale
   logic     a_valid_ff, a_valid_in;
   logic     a_below_ff, a_below_in;
   norm_type a_prod_ff,  a_prod_in;
   t_type    a_diff;

   always_comb begin
      a_valid_in = in_valid;
      a_below_in = (t_value < t_min);
      // 16-bit offset; below t_min is flagged and clamped in stage B
      a_diff     = t_value - t_min;
      a_prod_in  = norm_type'(a_diff) * norm_type'(t_inv_span);
   end

   // Stage B: clamp and rescale
   tnorm_type b_ff, b_in;
   q_type     q;
   q_ext_type q_ext;

   always_comb begin
      b_in.valid = a_valid_ff;
      b_in.err   = 1'b0;
      q          = a_prod_ff[Q_W-1:0];
      if (a_below_ff) begin
         q        = '0;
         b_in.err = 1'b1;
      end else if (a_prod_ff > NORM_ONE) begin
         q        = Q_ONE;
         b_in.err = 1'b1;
      end
      q_ext   = ((q_ext_type'(q) + Q_RND) >> TN_SHR) << TN_SHL;
      b_in.tn = q_ext[TN_W-1:0];
   end

   // Stage registers; only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_ff.valid <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_ff.valid <= b_in.valid;
      end
      if (advance) begin
         a_below_ff <= a_below_in;
         a_prod_ff  <= a_prod_in;
         b_ff.err   <= b_in.err;
         b_ff.tn    <= b_in.tn;
      end
   end

   assign norm_out = b_ff;

endmodule

`default_nettype wire

// File: hdl/cubic_bezier_point_tangent.sv
// Top level of the cubic Bezier point/tangent evaluator: control-point
// registers and the three de Casteljau lerp levels.
// Depends on cbpt_pkg, cbpt_if (interfaces) and cbpt_tnorm.
//
// Usage:
//   req_bus  carries one curve parameter t_value per request.
//   rsp_bus  returns the point (pos_x/y/z) and tangent (tan_x/y/z) plus
//            range_error when t was clamped to the segment ends.
//   csr_bus  writes point0..point3, t_min and t_inv_span by index; always
//            ready, unknown indexes are dropped. Write only while idle.
// Timing:
//   Six register stages (scale, clamp, three lerp levels, output). A
//   request accepted on req_bus passes them in that order to rsp_bus.
//   One request per cycle is taken as long as the receiver keeps up.
// Stall:
//   When the output register holds an untaken result, the whole pipeline
//   freezes and req_bus.ready drops; nothing is lost or repeated.
// Reset:
//   Clears all stage valid bits, control points and t_min to zero and
//   t_inv_span to 1.0 (Q16.16).
`default_nettype none

module cubic_bezier_point_tangent import cbpt_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   cbpt_req_if.sink   req_bus,
   cbpt_rsp_if.source rsp_bus,
   cbpt_csr_if.sink   csr_bus
);

   // Configuration registers
   point_type    point_ff [NUM_POINTS];
   t_type        t_min_ff;
   inv_span_type t_inv_span_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_ff[i] <= '0;
         end
         t_min_ff      <= '0;
         t_inv_span_ff <= INV_SPAN_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_POINT0:     point_ff[0]   <= csr_bus.data;
            CSR_POINT1:     point_ff[1]   <= csr_bus.data;
            CSR_POINT2:     point_ff[2]   <= csr_bus.data;
            CSR_POINT3:     point_ff[3]   <= csr_bus.data;
            CSR_T_MIN:      t_min_ff      <= csr_bus.data[T_W-1:0];
            CSR_T_INV_SPAN: t_inv_span_ff <= csr_bus.data[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // Global pipeline enable: move whenever the output slot is free or taken
   logic rsp_valid_ff;
   logic advance;

   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Parameter normalization (two stages)
   tnorm_type norm;

   cbpt_tnorm u_tnorm (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_bus.valid),
      .t_value    (req_bus.t_value),
      .t_min      (t_min_ff),
      .t_inv_span (t_inv_span_ff),
      .norm_out   (norm)
   );

   // Control stage registers for the lerp levels
   logic   c_valid_ff, d_valid_ff, e_valid_ff;
   logic   c_err_ff,   d_err_ff,   e_err_ff;
   tn_type c_tn_ff,    d_tn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff   <= norm.valid;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         rsp_valid_ff <= e_valid_ff;
      end
   end

   logic err_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         c_err_ff <= norm.err;
         c_tn_ff  <= norm.tn;
         d_err_ff <= c_err_ff;
         d_tn_ff  <= c_tn_ff;
         e_err_ff <= d_err_ff;
         err_ff   <= e_err_ff;
      end
   end

   // Per-axis datapath
   pos_type pos_ff [NUM_AXES];
   tan_type tan_ff [NUM_AXES];

   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
      coord_type c0, c1, c2, c3;

      assign c0 = coord_sel(point_ff[0], ax);
      assign c1 = coord_sel(point_ff[1], ax);
      assign c2 = coord_sel(point_ff[2], ax);
      assign c3 = coord_sel(point_ff[3], ax);

      // Level 1 products
      prod_type  c_p01_ff, c_p02_ff, c_p03_ff;
      prod_type  c_p01_in, c_p02_in, c_p03_in;
      // Level 1 finish, level 2 products
      coord_type p01, p02, p03;
      coord_type d_p01_ff, d_p02_ff;
      prod_type  d_p11_ff, d_p12_ff, d_p11_in, d_p12_in;
      // Level 2 finish, tangent, level 3 product
      coord_type   p11, p12;
      tan_raw_type tdiff, tan_raw;
      coord_type   e_p11_ff;
      prod_type    e_pos_ff, e_pos_in;
      tan_raw_type e_tan_ff;
      // Level 3 finish and saturation
      coord_type pos;
      sat_type   pos_sat, tan_sat;

      always_comb begin
         c_p01_in = lerp_mul(c0, c1, norm.tn);
         c_p02_in = lerp_mul(c1, c2, norm.tn);
         c_p03_in = lerp_mul(c2, c3, norm.tn);
      end

      always_comb begin
         p01      = lerp_end(c0, c_p01_ff);
         p02      = lerp_end(c1, c_p02_ff);
         p03      = lerp_end(c2, c_p03_ff);
         d_p11_in = lerp_mul(p01, p02, c_tn_ff);
         d_p12_in = lerp_mul(p02, p03, c_tn_ff);
      end

      always_comb begin
         p11      = lerp_end(d_p01_ff, d_p11_ff);
         p12      = lerp_end(d_p02_ff, d_p12_ff);
         tdiff    = tan_raw_type'(p12) - tan_raw_type'(p11);
         tan_raw  = (tdiff <<< 1) + tdiff;
         e_pos_in = lerp_mul(p11, p12, d_tn_ff);
      end

      always_comb begin
         pos     = lerp_end(e_p11_ff, e_pos_ff);
         pos_sat = sat_clip(sat_type'(pos), POS_HI, POS_LO);
         tan_sat = sat_clip(sat_type'(e_tan_ff), TAN_HI, TAN_LO);
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            c_p01_ff   <= c_p01_in;
            c_p02_ff   <= c_p02_in;
            c_p03_ff   <= c_p03_in;
            d_p01_ff   <= p01;
            d_p02_ff   <= p02;
            d_p11_ff   <= d_p11_in;
            d_p12_ff   <= d_p12_in;
            e_p11_ff   <= p11;
            e_pos_ff   <= e_pos_in;
            e_tan_ff   <= tan_raw;
            pos_ff[ax] <= pos_sat[POS_W-1:0];
            tan_ff[ax] <= tan_sat[TAN_W-1:0];
         end
      end
   end

   // Result channel
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pos_x       = pos_ff[0];
   assign rsp_bus.pos_y       = pos_ff[1];
   assign rsp_bus.pos_z       = pos_ff[2];
   assign rsp_bus.tan_x       = tan_ff[0];
   assign rsp_bus.tan_y       = tan_ff[1];
   assign rsp_bus.tan_z       = tan_ff[2];
   assign rsp_bus.range_error = err_ff;

`ifndef ASSERT_OFF
   a_tn_bounded: assert property (@(posedge clock) disable iff (reset)
      norm.valid |-> (norm.tn <= TN_ONE))
      else $error("normalized parameter above one");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(d_valid_ff) && $stable(e_valid_ff)))
      else $error("pipeline moved during a stall");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (advance && d_valid_ff) |=> e_valid_ff)
      else $error("request dropped between lerp stages");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
